// ===== design/eaf_pkg.sv =====
// ----------------------------------------------------------------------------
// eaf_pkg
// Types and constants shared by the egress address filter files.
// ----------------------------------------------------------------------------
package eaf_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   localparam int CMD_W  = 2;
   localparam int FAM_W  = 2;
   localparam int ADDR_W = 64;

   // stored entry: {is_v6, addr_hi, addr_lo}
   localparam int ENTRY_W = 1 + 2 * ADDR_W;

   localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
   localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

// ===== design/eaf_req_if.sv =====
// ----------------------------------------------------------------------------
// eaf_req_if
// Request channel of the egress address filter: command and address.
// ----------------------------------------------------------------------------
interface eaf_req_if
   import eaf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [FAM_W-1:0]  addr_family;
   logic [ADDR_W-1:0] addr_hi;
   logic [ADDR_W-1:0] addr_lo;

   modport source (output valid, output cmd, output addr_family,
                   output addr_hi, output addr_lo, input ready);
   modport sink   (input valid, input cmd, input addr_family,
                   input addr_hi, input addr_lo, output ready);
endinterface

// ===== design/eaf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// eaf_rsp_if
// Response channel of the egress address filter: verdict and status.
// ----------------------------------------------------------------------------
interface eaf_rsp_if;
   logic valid;
   logic ready;
   logic allowed;
   logic list_hit;
   logic status;

   modport source (output valid, output allowed, output list_hit,
                   output status, input ready);
   modport sink   (input valid, input allowed, input list_hit,
                   input status, output ready);
endinterface

// ===== design/eaf_ram.sv =====
// ----------------------------------------------------------------------------
// eaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eaf_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/egress_address_filter_core.sv =====
// ----------------------------------------------------------------------------
// egress_address_filter_core
// Allow-list plus fixed reserved-range policy for outgoing IPv4/IPv6 targets.
// ----------------------------------------------------------------------------
// One request at a time. Clear, append and unused commands go from
// acceptance straight to the result state. A check walks the allow-list
// held in a single RAM, one entry read per cycle with the compare in the
// cycle after each read, and stops at the first hit; an empty list or a
// family other than IPv4/IPv6 skips the walk. The response sits in an
// output register, so a new request is taken while the previous response
// waits. Entries are only read below the fill count, so the RAM needs no
// clearing after reset.
module egress_address_filter_core
   import eaf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   eaf_req_if.sink  req,
   eaf_rsp_if.source rsp
);

   localparam logic [31:0] MAPPED_TAG = 32'h0000_ffff;

   function automatic logic is_mapped(input logic [ADDR_W-1:0] hi,
                                      input logic [ADDR_W-1:0] lo);
      return (hi == '0) && (lo[63:32] == MAPPED_TAG);
   endfunction

   function automatic logic v4_reserved(input logic [31:0] a);
      logic [7:0] o1;
      logic [7:0] o2;
      logic [7:0] o3;
      logic [7:0] o4;
      logic       r;
      o1 = a[31:24];
      o2 = a[23:16];
      o3 = a[15:8];
      o4 = a[7:0];
      r  = 1'b0;
      if (o1 == 8'd168 && o2 == 8'd63 && o3 == 8'd129 && o4 == 8'd16) r = 1'b1;
      if ((o1 inside {8'd0, 8'd10, 8'd127}) || o1 >= 8'd224) r = 1'b1;
      if (o1 == 8'd100 && (o2 inside {[8'd64:8'd127]})) r = 1'b1;
      if (o1 == 8'd169 && o2 == 8'd254) r = 1'b1;
      if (o1 == 8'd172 && (o2 inside {[8'd16:8'd31]})) r = 1'b1;
      if (o1 == 8'd192 && (o2 == 8'd168 ||
                           (o2 == 8'd0 && (o3 inside {8'd0, 8'd2})) ||
                           (o2 == 8'd88 && o3 == 8'd99))) r = 1'b1;
      if (o1 == 8'd198 && ((o2 inside {8'd18, 8'd19}) ||
                           (o2 == 8'd51 && o3 == 8'd100))) r = 1'b1;
      if (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113) r = 1'b1;
      return r;
   endfunction

   function automatic logic v6_global_ok(input logic [ADDR_W-1:0] hi);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic       ok;
      b0 = hi[63:56];
      b1 = hi[55:48];
      b2 = hi[47:40];
      b3 = hi[39:32];
      ok = 1'b1;
      if ((b0 & 8'he0) != 8'h20) ok = 1'b0;
      if (b0 == 8'h20 && b1 == 8'h01 && b2 < 8'h02) ok = 1'b0;
      if (b0 == 8'h20 && b1 == 8'h01 && b2 == 8'h0d && b3 == 8'hb8) ok = 1'b0;
      if (b0 == 8'h20 && b1 == 8'h02) ok = 1'b0;
      if (b0 == 8'h3f && b1 == 8'hff && b2[7:4] == 4'h0) ok = 1'b0;
      if (b0 >= 8'hfc) ok = 1'b0;
      return ok;
   endfunction

   function automatic logic policy_ok(input logic v6,
                                      input logic [ADDR_W-1:0] hi,
                                      input logic [ADDR_W-1:0] lo);
      return v6 ? v6_global_ok(hi) : !v4_reserved(lo[31:0]);
   endfunction

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              issue_done_ff, issue_done_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              cmp_last_ff, cmp_last_in;
   logic              q_v6_ff, q_v6_in;
   logic [ADDR_W-1:0] q_hi_ff, q_hi_in;
   logic [ADDR_W-1:0] q_lo_ff, q_lo_in;
   logic              res_allowed_ff, res_allowed_in;
   logic              res_hit_ff, res_hit_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_allowed_ff, rsp_allowed_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              req_fire;
   cmd_type           req_cmd;
   logic              fam_ok;
   logic              in_v6;
   logic [ADDR_W-1:0] in_hi;
   logic [ADDR_W-1:0] in_lo;
   logic              list_full;
   logic              last_issue;
   logic              out_free;

   logic              wr_en;
   logic              rd_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic              e_v6;
   logic [ADDR_W-1:0] e_hi;
   logic [ADDR_W-1:0] e_lo;
   logic              entry_match;

   eaf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign req_fire  = req.valid && req.ready;
   assign req_cmd   = cmd_type'(req.cmd);
   assign fam_ok    = (req.addr_family == FAM_V4) || (req.addr_family == FAM_V6);
   assign in_v6     = (req.addr_family == FAM_V6);
   // IPv4 keeps only the low word of addr_lo
   assign in_hi     = in_v6 ? req.addr_hi : '0;
   assign in_lo     = in_v6 ? req.addr_lo : {32'h0, req.addr_lo[31:0]};
   assign list_full = (cnt_ff >= CNT_W'(LIST_DEPTH));
   assign wr_data   = {in_v6, in_hi, in_lo};

   assign last_issue = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == cnt_ff);
   assign out_free   = !rsp_vld_ff || rsp.ready;

   assign e_v6 = rd_data[ENTRY_W-1];
   assign e_hi = rd_data[2*ADDR_W-1:ADDR_W];
   assign e_lo = rd_data[ADDR_W-1:0];

   // exact match within a family, or via the ::ffff:a.b.c.d form across them
   always_comb begin
      if (e_v6 == q_v6_ff) begin
         entry_match = q_v6_ff ? (e_hi == q_hi_ff && e_lo == q_lo_ff)
                               : (e_lo[31:0] == q_lo_ff[31:0]);
      end else if (!q_v6_ff) begin
         entry_match = is_mapped(e_hi, e_lo) && (e_lo[31:0] == q_lo_ff[31:0]);
      end else begin
         entry_match = is_mapped(q_hi_ff, q_lo_ff) &&
                       (q_lo_ff[31:0] == e_lo[31:0]);
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      issue_done_in  = issue_done_ff;
      cmp_vld_in     = 1'b0;
      cmp_last_in    = cmp_last_ff;
      q_v6_in        = q_v6_ff;
      q_hi_in        = q_hi_ff;
      q_lo_in        = q_lo_ff;
      res_allowed_in = res_allowed_ff;
      res_hit_in     = res_hit_ff;
      res_status_in  = res_status_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      req.ready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req_fire) begin
               q_v6_in        = in_v6;
               q_hi_in        = in_hi;
               q_lo_in        = in_lo;
               res_allowed_in = 1'b0;
               res_hit_in     = 1'b0;
               res_status_in  = 1'b0;
               rd_idx_in      = '0;
               issue_done_in  = 1'b0;
               state_in       = ST_RESULT;
               case (req_cmd)
                  CMD_CLEAR: begin
                     cnt_in = '0;
                  end
                  CMD_APPEND: begin
                     if (fam_ok) begin
                        if (list_full) begin
                           res_status_in = 1'b1;
                        end else begin
                           wr_en  = 1'b1;
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                     end
                  end
                  CMD_CHECK: begin
                     if (fam_ok) begin
                        if (cnt_ff == '0) begin
                           res_allowed_in = policy_ok(in_v6, in_hi, in_lo);
                        end else begin
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read address runs one entry ahead of the compare
            if (!issue_done_ff) begin
               rd_en       = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_last_in = last_issue;
               if (last_issue) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (cmp_vld_ff) begin
               if (entry_match) begin
                  res_hit_in     = 1'b1;
                  res_allowed_in = 1'b1;
                  cmp_vld_in     = 1'b0;
                  state_in       = ST_RESULT;
               end else if (cmp_last_ff) begin
                  res_allowed_in = policy_ok(q_v6_ff, q_hi_ff, q_lo_ff);
                  cmp_vld_in     = 1'b0;
                  state_in       = ST_RESULT;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_vld_in     = 1'b1;
               rsp_allowed_in = res_allowed_ff;
               rsp_hit_in     = res_hit_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_idx_ff     <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_idx_ff     <= rd_idx_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_last_ff    <= cmp_last_in;
      q_v6_ff        <= q_v6_in;
      q_hi_ff        <= q_hi_in;
      q_lo_ff        <= q_lo_in;
      res_allowed_ff <= res_allowed_in;
      res_hit_ff     <= res_hit_in;
      res_status_ff  <= res_status_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp.valid    = rsp_vld_ff;
   assign rsp.allowed  = rsp_allowed_ff;
   assign rsp.list_hit = rsp_hit_ff;
   assign rsp.status   = rsp_status_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LIST_DEPTH))
      else $error("allow-list fill count beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_CLEAR) |=> (cnt_ff == '0))
      else $error("clear request did not empty the list");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!list_full && state_ff == ST_IDLE))
      else $error("list write without room");

   a_hit_allows: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_hit_ff) |-> (rsp_allowed_ff && !rsp_status_ff))
      else $error("list hit response not allowed or flagged as error");

endmodule
